FILE: hdl/rau_pkg.sv
// Package for the rational arithmetic unit: operation codes and payload types.
// No dependencies.
package rau_pkg;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_CMP = 3'd4;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } rau_in_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic               den_zero;
        logic               overflow;
        logic               less;
        logic               equal;
    } rau_out_t;

endpackage

FILE: hdl/rational_arith_unit.sv
// Top level of the rational arithmetic unit.
// Depends on rau_pkg and rau_divider.
//
// Computes a+b, a-b, a*b or a/b of two signed fractions, reduces the result by
// the gcd and normalizes the denominator sign, or compares the two fractions. One
// transaction is in flight at a time, and in_ready stays low until the result
// has been taken. An undefined code goes from the products straight to the
// output with a zero result, and a compare goes to the output after the sum
// step. Arithmetic runs the shared bit-serial divider once per Euclid step of
// the double-width products, then twice more to divide both parts by the gcd.
// When both parts are zero, the reduction is skipped.
module rational_arith_unit
#(
    parameter int WIDTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rau_pkg::rau_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rau_pkg::rau_out_t out_data
);
    import rau_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_PROD = 8'b00000010,
        S_SUM  = 8'b00000100,
        S_GCD  = 8'b00001000,
        S_RN   = 8'b00010000,
        S_RD   = 8'b00100000,
        S_FIN  = 8'b01000000,
        S_OUT  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [32:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [63:0] p_reg, q_reg;
    logic [2:0]  op_reg;
    logic [63:0] nm_reg, dm_reg, gx_reg, gy_reg;
    logic        nneg_reg;
    logic        div_wait_reg;
    rau_out_t    out_reg;

    logic        div_start;
    logic [63:0] div_a, div_b, div_q, div_r;
    logic        div_done;

    rau_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    function automatic logic signed [32:0] sext_w(input logic [31:0] v);
        logic [WIDTH-1:0] t;
        t = v[WIDTH-1:0];
        return 33'(signed'(t));
    endfunction

    localparam logic [63:0] HALF = 64'd1 << (WIDTH - 1);

    logic signed [32:0] s_an, s_ad, s_bn, s_bd;
    logic [63:0] sum;
    logic        ps_neg;

    always_comb
    begin
        s_an = sext_w(in_data.a_num);
        s_ad = sext_w(in_data.a_den);
        s_bn = sext_w(in_data.b_num);
        s_bd = sext_w(in_data.b_den);
        sum  = p_reg + q_reg;
        if (p_reg < 0 && q_reg < 0)
            ps_neg = 1'b1;
        else if (p_reg >= 0 && q_reg >= 0)
            ps_neg = 1'b0;
        else
            ps_neg = sum[63];
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = out_reg;

    always_comb
    begin
        div_a = gx_reg;
        div_b = gy_reg;
        if (state_reg == S_RN)
        begin
            div_a = nm_reg;
            div_b = gx_reg;
        end
        else if (state_reg == S_RD)
        begin
            div_a = dm_reg;
            div_b = gx_reg;
        end
        div_start = 1'b0;
        if ((state_reg == S_GCD || state_reg == S_RN || state_reg == S_RD) && !div_wait_reg
            && !(state_reg == S_GCD && gy_reg == 64'd0))
            div_start = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            div_wait_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (div_start)
                div_wait_reg <= 1'b1;
            else if (div_done)
                div_wait_reg <= 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid) state_next = S_PROD;
            S_PROD: state_next = (op_reg > OP_CMP) ? S_OUT : S_SUM;
            S_SUM:  state_next = (op_reg == OP_CMP) ? S_OUT : S_GCD;
            S_GCD:  if (!div_wait_reg && gy_reg == 64'd0)
                        state_next = (gx_reg == 64'd0) ? S_FIN : S_RN;
            S_RN:   if (div_done) state_next = S_RD;
            S_RD:   if (div_done) state_next = S_FIN;
            S_FIN:  state_next = S_OUT;
            S_OUT:  if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath. The cross products come from 33-bit signed operands.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                op_reg <= in_data.op;
                an_reg <= (s_ad < 0) ? -s_an : s_an;
                ad_reg <= (s_ad < 0) ? -s_ad : s_ad;
                bn_reg <= (s_bd < 0) ? -s_bn : s_bn;
                bd_reg <= (s_bd < 0) ? -s_bd : s_bd;
            end
            S_PROD:
            begin
                out_reg <= '0;
                unique case (op_reg)
                    OP_ADD, OP_CMP:
                    begin
                        p_reg <= an_reg * bd_reg;
                        q_reg <= bn_reg * ad_reg;
                    end
                    OP_SUB:
                    begin
                        p_reg <= an_reg * bd_reg;
                        q_reg <= -(bn_reg * ad_reg);
                    end
                    OP_MUL:
                    begin
                        p_reg <= an_reg * bn_reg;
                        q_reg <= ad_reg * bd_reg;
                    end
                    OP_DIV:
                    begin
                        p_reg <= an_reg * bd_reg;
                        q_reg <= ad_reg * bn_reg;
                    end
                    default:
                    begin
                        p_reg <= '0;
                        q_reg <= '0;
                    end
                endcase
            end
            S_SUM:
            begin
                if (op_reg == OP_CMP)
                begin
                    out_reg.less  <= p_reg < q_reg;
                    out_reg.equal <= p_reg == q_reg;
                end
                else if (op_reg == OP_ADD || op_reg == OP_SUB)
                begin
                    nneg_reg <= ps_neg;
                    nm_reg   <= ps_neg ? -sum : sum;
                    dm_reg   <= ad_reg * bd_reg;
                    gx_reg   <= ps_neg ? -sum : sum;
                    gy_reg   <= ad_reg * bd_reg;
                end
                else
                begin
                    nneg_reg <= p_reg[63] ^ (q_reg[63] && q_reg != 0);
                    nm_reg   <= p_reg[63] ? -p_reg : p_reg;
                    dm_reg   <= q_reg[63] ? -q_reg : q_reg;
                    gx_reg   <= p_reg[63] ? -p_reg : p_reg;
                    gy_reg   <= q_reg[63] ? -q_reg : q_reg;
                end
            end
            S_GCD:
                if (div_done)
                begin
                    gx_reg <= gy_reg;
                    gy_reg <= div_r;
                end
            S_RN:
                if (div_done) nm_reg <= div_q;
            S_RD:
                if (div_done) dm_reg <= div_q;
            S_FIN:
            begin
                if (dm_reg == 64'd0)
                begin
                    out_reg.res_num  <= (nneg_reg && nm_reg != 0) ? -nm_reg[31:0]
                                                                   : nm_reg[31:0];
                    out_reg.den_zero <= 1'b1;
                end
                else if (nm_reg > ((nneg_reg && nm_reg != 0) ? HALF : HALF - 64'd1)
                         || dm_reg > HALF - 64'd1)
                    out_reg.overflow <= 1'b1;
                else
                begin
                    out_reg.res_num <= (nneg_reg && nm_reg != 0) ? -nm_reg[31:0]
                                                                  : nm_reg[31:0];
                    out_reg.res_den <= dm_reg[30:0];
                end
            end
            default: ;
        endcase
    end
endmodule

FILE: hdl/rau_divider.sv
// Restoring 64-bit divider, one quotient bit per cycle.
// Depends on nothing; used by rational_arith_unit for gcd remainders and the reduction.
module rau_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient,
    output logic [63:0] remainder
);
    logic [63:0] quo_reg, quo_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;
    logic [64:0] shifted;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[63]};
        trial     = shifted - {1'b0, dvs_reg};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[63:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

FILE: hdl/rau_checker.sv
// Port checker for rational_arith_unit, bound to the top level.
// Depends on rau_pkg.
module rau_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input rau_pkg::rau_out_t out_data
);
    a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.den_zero && out_data.overflow))
        else $error("den_zero with overflow");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("ready after accept");
endmodule

bind rational_arith_unit rau_checker u_rau_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
